[hdl/impulse_clock_pulse_generator_defines.svh]
// Assertion macros shared by the impulse clock pulse generator modules.
// No dependencies; assertions drop out when SYNTHESIS is defined.
`ifndef IMPULSE_CLOCK_PULSE_GENERATOR_DEFINES_SVH
`define IMPULSE_CLOCK_PULSE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define ICPG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("impulse clock pulse generator: assertion failed");
// property checked at every edge, reset included
`define ICPG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("impulse clock pulse generator: assertion failed");
`else
`define ICPG_ASSERT(label, clk, rst_n, prop)
`define ICPG_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hdl/icpg_pkg.sv]
// Package for the impulse clock pulse generator: field widths, constants,
// opcodes and the item structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icpg_pkg;

    // field and internal widths
    localparam int unsigned TIME_W  = 17;
    localparam int unsigned DIAL_W  = 11;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned FORCE_W = 8;

    // timing constants
    localparam int unsigned DEFAULT_PERIOD_SECONDS = 43200;
    localparam int unsigned SEC_PER_MIN     = 60;
    localparam int unsigned MIN_PER_HOUR    = 60;
    localparam int unsigned SEC_PER_HOUR    = 3600;
    localparam int unsigned FAST_WINDOW_SEC = 30 * 60;

    // pulse pattern constants
    localparam int unsigned A_BURST_MINUTE = 59;
    localparam int unsigned B_LAST_MINUTE  = 49;
    localparam int unsigned A_BURST_FIRST  = 10;
    localparam int unsigned A_BURST_LAST   = 50;
    localparam int unsigned FORCE_MAX      = 255;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_DIAL = 2'd1,
        OP_FORCE_A  = 2'd2,
        OP_FORCE_B  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [TIME_W-1:0]   now_time;
        logic                run_pressed;
        logic                time_synced;
        logic                save_ok;
    } t_in_item;

    typedef struct packed {
        logic                pulse_a;
        logic                pulse_b;
        logic                pulse_d;
        logic [DIAL_W-1:0]   dial_minutes;
        logic                dial_known;
    } t_out_item;

    // command with its time already split into seconds, minutes, hours
    typedef struct packed {
        t_opcode             opcode;
        logic                run_pressed;
        logic                time_synced;
        logic                save_ok;
        logic [TIME_W-1:0]   now_sec;
        logic [DIAL_W-1:0]   now_min;
        logic [HOUR_W-1:0]   now_hour;
    } t_split;

endpackage

`default_nettype wire

[hdl/icpg_time_split.sv]
// Input register and three constant-divider stages: reduces the time modulo
// the period and splits it into minute and hour counts. Uses icpg_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "impulse_clock_pulse_generator_defines.svh"

module icpg_time_split
    import icpg_pkg::*;
#(
    parameter int unsigned PERIOD_SECONDS = DEFAULT_PERIOD_SECONDS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_split        o_split
);

    localparam int unsigned TW = TIME_W;

    // exact reciprocals for any dividend below 2**TW
    localparam int unsigned SH_P = TW + $clog2(PERIOD_SECONDS);
    localparam int unsigned SH_M = TW + $clog2(SEC_PER_MIN);
    localparam int unsigned SH_H = TW + $clog2(SEC_PER_HOUR);
    localparam int unsigned MUL_W = TW + 2;
    localparam int unsigned PROD_W = TW + MUL_W;
    localparam logic [63:0] MUL_P =
        ((64'd1 << SH_P) + 64'(PERIOD_SECONDS) - 64'd1) / 64'(PERIOD_SECONDS);
    localparam logic [63:0] MUL_M =
        ((64'd1 << SH_M) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN);
    localparam logic [63:0] MUL_H =
        ((64'd1 << SH_H) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR);

    // largest number of whole periods in a raw time value
    localparam int unsigned Q_MAX = ((1 << TW) - 1) / PERIOD_SECONDS;
    localparam int unsigned Q_W = (Q_MAX > 1) ? $clog2(Q_MAX + 1) : 1;

    typedef struct packed {
        t_opcode         opcode;
        logic            run_pressed;
        logic            time_synced;
        logic            save_ok;
        logic [TW-1:0]   now_time;
        logic [Q_W-1:0]  periods;
    } t_stage1;

    typedef struct packed {
        t_opcode         opcode;
        logic            run_pressed;
        logic            time_synced;
        logic            save_ok;
        logic [TW-1:0]   now_sec;
    } t_stage2;

    logic [3:0]        r_valid;
    t_in_item          r_in;
    t_stage1           r_s1;
    t_stage1           n_s1;
    t_stage2           r_s2;
    t_stage2           n_s2;
    t_split            r_s3;
    t_split            n_s3;
    logic [3:0]        stg_ready;
    logic [PROD_W-1:0] prod_p;
    logic [PROD_W-1:0] prod_m;
    logic [PROD_W-1:0] prod_h;
    logic [TW-1:0]     period_part;

    // each stage moves when it is empty or its successor moves
    assign stg_ready[3] = !r_valid[3] || i_ready;
    assign stg_ready[2] = !r_valid[2] || stg_ready[3];
    assign stg_ready[1] = !r_valid[1] || stg_ready[2];
    assign stg_ready[0] = !r_valid[0] || stg_ready[1];
    assign o_ready = stg_ready[0];
    assign o_valid = r_valid[3];
    assign o_split = r_s3;

    // stage 1: number of whole periods in the raw time
    assign prod_p = PROD_W'(r_in.now_time) * PROD_W'(MUL_P);
    always_comb begin
        n_s1.opcode      = r_in.opcode;
        n_s1.run_pressed = r_in.run_pressed;
        n_s1.time_synced = r_in.time_synced;
        n_s1.save_ok     = r_in.save_ok;
        n_s1.now_time    = r_in.now_time;
        n_s1.periods     = Q_W'(prod_p >> SH_P);
    end

    // stage 2: remainder within the period
    assign period_part = TW'(r_s1.periods) * TW'(PERIOD_SECONDS);
    always_comb begin
        n_s2.opcode      = r_s1.opcode;
        n_s2.run_pressed = r_s1.run_pressed;
        n_s2.time_synced = r_s1.time_synced;
        n_s2.save_ok     = r_s1.save_ok;
        n_s2.now_sec     = r_s1.now_time - period_part;
    end

    // stage 3: whole minutes and whole hours of the period time
    assign prod_m = PROD_W'(r_s2.now_sec) * PROD_W'(MUL_M);
    assign prod_h = PROD_W'(r_s2.now_sec) * PROD_W'(MUL_H);
    always_comb begin
        n_s3.opcode      = r_s2.opcode;
        n_s3.run_pressed = r_s2.run_pressed;
        n_s3.time_synced = r_s2.time_synced;
        n_s3.save_ok     = r_s2.save_ok;
        n_s3.now_sec     = r_s2.now_sec;
        n_s3.now_min     = DIAL_W'(prod_m >> SH_M);
        n_s3.now_hour    = HOUR_W'(prod_h >> SH_H);
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stg_ready[0]) r_valid[0] <= i_valid;
            if (stg_ready[1]) r_valid[1] <= r_valid[0];
            if (stg_ready[2]) r_valid[2] <= r_valid[1];
            if (stg_ready[3]) r_valid[3] <= r_valid[2];
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (stg_ready[0] && i_valid) r_in <= i_item;
        if (stg_ready[1] && r_valid[0]) r_s1 <= n_s1;
        if (stg_ready[2] && r_valid[1]) r_s2 <= n_s2;
        if (stg_ready[3] && r_valid[2]) r_s3 <= n_s3;
    end

    // divider results stay consistent
    `ICPG_ASSERT(a_now_in_period, i_clk, i_rst_n, r_valid[3] |-> r_s3.now_sec < TW'(PERIOD_SECONDS))
    `ICPG_ASSERT(a_minute_split, i_clk, i_rst_n, r_valid[3] |-> (r_s3.now_sec - TW'(r_s3.now_min) * TW'(SEC_PER_MIN)) < TW'(SEC_PER_MIN))

endmodule

`default_nettype wire

[hdl/icpg_core.sv]
// Dial and pulse state with the result register: applies one command per
// cycle unless the output stalls, and computes the A, B and D levels. Uses icpg_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "impulse_clock_pulse_generator_defines.svh"

module icpg_core
    import icpg_pkg::*;
#(
    parameter int unsigned PERIOD_SECONDS = DEFAULT_PERIOD_SECONDS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_split i_split,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_out_item   o_item
);

    localparam int unsigned TW = TIME_W;
    localparam int unsigned DISP_W = TW + 1;
    localparam int unsigned MINUTES = PERIOD_SECONDS / SEC_PER_MIN;
    localparam logic [TW-1:0] FAST_LIMIT = TW'(PERIOD_SECONDS - FAST_WINDOW_SEC);

    logic [DIAL_W-1:0]  r_dial;
    logic [DIAL_W-1:0]  n_dial;
    logic [TW-1:0]      r_last;
    logic [TW-1:0]      n_last;
    logic               r_known;
    logic               n_known;
    logic [FORCE_W-1:0] r_fa;
    logic [FORCE_W-1:0] n_fa;
    logic [FORCE_W-1:0] r_fb;
    logic [FORCE_W-1:0] n_fb;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    logic               take;
    logic [SEC_W-1:0]   sec;
    logic [SEC_W-1:0]   minute;
    logic               sec_zero;
    logic               a_burst;
    logic               b_window;
    logic [DISP_W-1:0]  disp_raw;
    logic [DISP_W-1:0]  disp_mod;
    logic [DISP_W-1:0]  delta_raw;
    logic [TW-1:0]      delta;
    logic               dial_fast;
    logic               dial_slow;
    logic [DIAL_W-1:0]  dial_inc;
    logic [DIAL_W-1:0]  dial_next;

    // output register handshake
    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // second of the minute and minute of the hour
    assign sec = SEC_W'(i_split.now_sec - TW'(i_split.now_min) * TW'(SEC_PER_MIN));
    assign minute = SEC_W'(i_split.now_min
                           - DIAL_W'(i_split.now_hour) * DIAL_W'(MIN_PER_HOUR));
    assign sec_zero = (sec == '0);
    assign a_burst  = (minute == SEC_W'(A_BURST_MINUTE)) && !sec[0]
                      && (sec >= SEC_W'(A_BURST_FIRST)) && (sec <= SEC_W'(A_BURST_LAST));
    assign b_window = (minute <= SEC_W'(B_LAST_MINUTE));

    // seconds from the end of the shown minute to real time, modulo the period
    assign disp_raw = DISP_W'(r_dial) * DISP_W'(SEC_PER_MIN) + DISP_W'(SEC_PER_MIN);
    assign disp_mod = (disp_raw >= DISP_W'(PERIOD_SECONDS))
                      ? disp_raw - DISP_W'(PERIOD_SECONDS) : disp_raw;
    assign delta_raw = (DISP_W'(i_split.now_sec) >= disp_mod)
                       ? DISP_W'(i_split.now_sec) - disp_mod
                       : DISP_W'(i_split.now_sec) + DISP_W'(PERIOD_SECONDS) - disp_mod;
    assign delta = (r_known && i_split.time_synced) ? TW'(delta_raw) : '0;
    assign dial_fast = (delta > FAST_LIMIT);
    assign dial_slow = (delta > TW'(SEC_PER_MIN));

    // dial advance with wrap at the end of the period
    assign dial_inc  = r_dial + 1'b1;
    assign dial_next = (dial_inc >= DIAL_W'(MINUTES)) ? dial_inc - DIAL_W'(MINUTES) : dial_inc;

    // command decode and next state
    always_comb begin
        n_dial  = r_dial;
        n_last  = r_last;
        n_known = r_known;
        n_fa    = r_fa;
        n_fb    = r_fb;
        n_out   = '0;
        case (i_split.opcode)
            OP_SET_DIAL: begin
                n_dial = i_split.now_min;
            end
            OP_FORCE_A: begin
                if (r_fa != FORCE_W'(FORCE_MAX)) n_fa = r_fa + 1'b1;
            end
            OP_FORCE_B: begin
                if (r_fb != FORCE_W'(FORCE_MAX)) n_fb = r_fb + 1'b1;
            end
            OP_TICK: begin
                if (i_split.now_sec != r_last) begin
                    n_last = i_split.now_sec;
                    if (i_split.run_pressed) begin
                        // run switch: pulse everything, align the dial
                        n_out.pulse_a = 1'b1;
                        n_out.pulse_b = 1'b1;
                        n_out.pulse_d = 1'b1;
                        n_dial  = i_split.now_min;
                        n_known = 1'b1;
                    end else if (!dial_fast) begin
                        if (dial_slow) begin
                            // catch up one minute per second
                            n_out.pulse_a = 1'b1;
                            n_out.pulse_b = 1'b1;
                            n_out.pulse_d = 1'b1;
                            n_dial = dial_next;
                        end else begin
                            // on time: normal pattern, forced pulses first
                            if (r_fa != '0) begin
                                n_out.pulse_a = 1'b1;
                                n_fa = r_fa - 1'b1;
                            end else begin
                                n_out.pulse_a = sec_zero || a_burst;
                            end
                            if (r_fb != '0) begin
                                n_out.pulse_b = 1'b1;
                                n_fb = r_fb - 1'b1;
                            end else begin
                                n_out.pulse_b = sec_zero && b_window;
                            end
                            n_out.pulse_d = sec_zero;
                            if (sec_zero) n_dial = dial_next;
                        end
                    end
                    // first sync: trust the saved dial time
                    if (!n_known && i_split.time_synced) begin
                        n_known = i_split.save_ok;
                        if (i_split.save_ok) n_dial = i_split.now_min;
                    end
                end
            end
            default: begin
                n_dial = r_dial;
            end
        endcase
        n_out.dial_minutes = n_dial;
        n_out.dial_known   = n_known;
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dial      <= '0;
            r_last      <= '0;
            r_known     <= 1'b0;
            r_fa        <= '0;
            r_fb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_dial  <= n_dial;
                r_last  <= n_last;
                r_known <= n_known;
                r_fa    <= n_fa;
                r_fb    <= n_fb;
            end
            if (o_ready) r_out_valid <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) r_out <= n_out;
    end

    `ICPG_ASSERT(a_dial_in_range, i_clk, i_rst_n, r_dial <= DIAL_W'(MINUTES))
    `ICPG_ASSERT(a_known_sticky, i_clk, i_rst_n, $past(i_rst_n) && $past(r_known) |-> r_known)
    `ICPG_ASSERT(a_cmd_pulses_low, i_clk, i_rst_n, take && i_split.opcode != OP_TICK |=> !r_out.pulse_a && !r_out.pulse_b && !r_out.pulse_d)
    `ICPG_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !$past(i_rst_n) |-> !r_out_valid)

endmodule

`default_nettype wire

[hdl/impulse_clock_pulse_generator.sv]
// Top level of the impulse clock pulse generator: time splitter followed by
// the dial and pulse core. Uses icpg_pkg, icpg_time_split and icpg_core.
//
// Takes one command item per clock cycle while the output is not stalled
// and gives exactly one result item for each, in order. An accepted item
// passes through one input register, three stages that reduce the time modulo
// the period and split it into minutes and hours with constant reciprocal
// multipliers, and the result register, where the dial, last-second and
// forced-pulse state is updated in the same cycle. A stalled output holds
// the pipeline stage by stage, so empty stages still fill. The period in
// seconds is the PERIOD_SECONDS parameter (3600 to 86400).
`timescale 1ns / 1ps
`default_nettype none

module impulse_clock_pulse_generator
    import icpg_pkg::*;
#(
    parameter int unsigned PERIOD_SECONDS = DEFAULT_PERIOD_SECONDS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    logic   split_valid;
    logic   core_ready;
    t_split split_item;

    // time reduction and split
    icpg_time_split #(
        .PERIOD_SECONDS(PERIOD_SECONDS)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (split_valid),
        .i_ready (core_ready),
        .o_split (split_item)
    );

    // dial state and pulse levels
    icpg_core #(
        .PERIOD_SECONDS(PERIOD_SECONDS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_ready (core_ready),
        .i_split (split_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire
